/* sv/ptd_pkg.sv */
// Package: shared types and constants of the periodic task dispatcher.
`default_nettype none
package ptd_pkg;
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int DATA_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] DEFAULT_INTERVAL_RESET = 32'd50;
  localparam logic [2:0] START_NOW_BIT = 3'h4;
  localparam logic [2:0] STORED_STATUS_MASK = 3'h3;
  localparam logic [2:0] STATUS_ERROR = 3'd7;
  localparam logic [2:0] STATUS_SCHEDULED = 3'd1;
  localparam logic [2:0] STATUS_ONE_TIME = 3'd2;
  localparam logic [2:0] STATUS_PAUSED = 3'd0;
  localparam logic [2:0] STATUS_MAX = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 1'd1;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0, KIND_REMOVE = 3'd1, KIND_MODIFY = 3'd2, KIND_PAUSE = 3'd3,
    KIND_RESUME = 3'd4, KIND_QUERY = 3'd5, KIND_TICK = 3'd6, KIND_SCAN = 3'd7
  } kind_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] interval;
    logic [2:0]        status;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [2:0]        task_status;
    logic              dispatch;
    logic [SLOT_W-1:0] dispatched_slot;
  } rsp_t;

  // Classified command handed from front to back.
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] interval;
    logic [2:0]        status;
    logic              slot_ok;
  } cmd_t;
endpackage
`default_nettype wire

/* sv/ptd_if.sv */
// Interfaces: request and response channels.
`default_nettype none
interface ptd_req_if;
  import ptd_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptd_rsp_if;
  import ptd_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/periodic_task_dispatcher_core.sv */
// Top level: periodic task dispatcher, front queue plus table back end.
//
//  channel | dir | payload                                   | handshake
//  req     | in  | kind, slot, interval, status              | valid/ready
//  rsp     | out | ok, task_status, dispatch, dispatched_slot| valid/ready
//  cfg     | in  | cfg_idx, cfg_data                         | cfg_we only
//
// One transaction per cycle sustained: the back end executes one queued
// command each cycle on register arrays. A request waits in the two-entry
// front queue and its response is held in the response register. Reset is
// synchronous; only control state and the presence bits clear. A stalled
// response holds the back end; the queue keeps accepting until both
// entries are full.
`default_nettype none
module periodic_task_dispatcher_core (
  input  wire logic clk,
  input  wire logic rst,
  ptd_req_if.sink   req,
  ptd_rsp_if.source rsp,
  input  wire logic cfg_we,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ptd_pkg::DATA_W-1:0]    cfg_data
);
  import ptd_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Accept and classify.
  ptd_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  // Execute against the table.
  ptd_back u_back (
    .clk(clk), .rst(rst),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .rsp(rsp)
  );

  // Back end must always be ready to take a command while no response is pending.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> cmd_ready) else $error("back end stalled while idle");

  // A dispatch result always reports success.
  a_dispatch_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.dispatch |-> rsp.data.ok) else $error("dispatch without ok");

  // Stalled response holds until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response changed under stall");
endmodule
`default_nettype wire

/* sv/ptd_front.sv */
// Front end: accept requests, classify them, and queue commands.
`default_nettype none
module ptd_front (
  input  wire logic         clk,
  input  wire logic         rst,
  ptd_req_if.sink           req,
  output ptd_pkg::cmd_t     cmd,
  output logic              cmd_valid,
  input  wire logic         cmd_ready
);
  import ptd_pkg::*;

  cmd_t q [QUEUE_DEPTH];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;
  cmd_t in_cmd;

  always_comb begin
    in_cmd.kind = kind_t'(req.data.kind);
    in_cmd.slot = req.data.slot;
    in_cmd.interval = req.data.interval;
    in_cmd.status = req.data.status;
    in_cmd.slot_ok = ({1'b0, req.data.slot} < (SLOT_W+1)'(TASK_SLOTS));
  end

  assign req.ready = (fill != 2'(QUEUE_DEPTH));
  assign push = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/ptd_back.sv */
// Back end: task table, ring links, tick counter, and response register.
`default_nettype none
module ptd_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ptd_pkg::cmd_t            cmd,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire logic                     cfg_we,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ptd_pkg::DATA_W-1:0]    cfg_data,
  ptd_rsp_if.source                     rsp
);
  import ptd_pkg::*;

  logic [DATA_W-1:0] default_interval, max_interval, tick_counter;
  logic [CNT_W-1:0]  task_count;
  logic [SLOT_W-1:0] ring_head, scan_pointer;
  logic [TASK_SLOTS-1:0] slot_present;
  logic [2:0]        slot_status [TASK_SLOTS];
  logic [DATA_W-1:0] slot_period [TASK_SLOTS];
  logic [DATA_W-1:0] slot_deadline [TASK_SLOTS];
  logic [SLOT_W-1:0] ring_next [TASK_SLOTS];
  logic [SLOT_W-1:0] ring_prev [TASK_SLOTS];

  logic go;
  logic usable, full;
  logic [DATA_W-1:0] add_ivl;
  logic [2:0] add_st;
  logic [SLOT_W-1:0] s, tail, nx, pv, c;
  logic [DATA_W-1:0] lag;
  logic due;
  rsp_t r;

  assign cmd_ready = !rsp.valid || rsp.ready;
  assign go = cmd_valid && cmd_ready;
  assign s = cmd.slot;
  assign usable = cmd.slot_ok && slot_present[s];
  assign full = (task_count == CNT_W'(TASK_SLOTS));
  assign tail = ring_prev[ring_head];
  assign nx = ring_next[s];
  assign pv = ring_prev[s];
  assign c = scan_pointer;
  assign add_ivl = (cmd.interval == '0 || cmd.interval > max_interval) ?
                   default_interval : cmd.interval;
  assign add_st = (cmd.status == STATUS_ERROR) ? STATUS_SCHEDULED : cmd.status;
  assign lag = tick_counter - slot_deadline[c];
  assign due = (slot_status[c] != STATUS_PAUSED) && !lag[DATA_W-1];

  always_comb begin
    r = '0;
    case (cmd.kind)
      KIND_ADD:    r.ok = cmd.slot_ok && !slot_present[s] && !full;
      KIND_REMOVE: r.ok = usable && task_count != '0;
      KIND_MODIFY: r.ok = usable && cmd.status <= STATUS_MAX;
      KIND_PAUSE, KIND_RESUME: r.ok = usable && !full;
      KIND_QUERY: begin
        r.ok = usable;
        r.task_status = usable ? slot_status[s] : STATUS_ERROR;
      end
      KIND_TICK: r.ok = 1'b1;
      KIND_SCAN: begin
        r.ok = task_count != '0;
        r.dispatch = r.ok && due;
        r.dispatched_slot = r.dispatch ? c : '0;
      end
      default: r = '0;
    endcase
  end

  // Table and link arrays need no reset: every read is guarded by slot_present or a nonzero task_count.
  always_ff @(posedge clk) begin
    if (go && r.ok) begin
      case (cmd.kind)
        KIND_ADD: begin
          if (task_count == '0) begin
            ring_next[s] <= s;
            ring_prev[s] <= s;
          end else begin
            ring_next[tail] <= s;
            ring_prev[s] <= tail;
            ring_next[s] <= ring_head;
            ring_prev[ring_head] <= s;
          end
          slot_deadline[s] <= tick_counter + ((add_st & START_NOW_BIT) != '0 ? '0 : add_ivl);
          slot_period[s] <= add_ivl;
          slot_status[s] <= add_st & STORED_STATUS_MASK;
        end
        KIND_REMOVE: begin
          ring_next[pv] <= nx;
          ring_prev[nx] <= pv;
        end
        KIND_MODIFY: begin
          slot_period[s] <= cmd.interval;
          slot_status[s] <= cmd.status;
          slot_deadline[s] <= (cmd.status == STATUS_SCHEDULED ||
                               cmd.status == STATUS_ONE_TIME) ?
                              tick_counter + cmd.interval : '0;
        end
        KIND_PAUSE: slot_status[s] <= STATUS_PAUSED;
        KIND_RESUME: begin
          slot_status[s] <= STATUS_SCHEDULED;
          slot_deadline[s] <= tick_counter + slot_period[s];
        end
        KIND_SCAN: begin
          if (due) begin
            if ((slot_status[c] & STATUS_ONE_TIME) != '0)
              slot_status[c] <= STATUS_PAUSED;
            else
              slot_deadline[c] <= tick_counter + slot_period[c];
          end
        end
        default: ;
      endcase
    end
    if (go) rsp.data <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_interval <= DEFAULT_INTERVAL_RESET;
      max_interval <= '1;
      tick_counter <= '0;
      task_count <= '0;
      ring_head <= '0;
      scan_pointer <= '0;
      slot_present <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_DEFAULT_INTERVAL) default_interval <= cfg_data;
        else if (cfg_idx == CFG_MAX_INTERVAL) max_interval <= cfg_data;
      end
      if (go) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      if (go && r.ok) begin
        case (cmd.kind)
          KIND_ADD: begin
            if (task_count == '0) begin
              ring_head <= s;
              scan_pointer <= s;
            end
            slot_present[s] <= 1'b1;
            task_count <= task_count + CNT_W'(1);
          end
          KIND_REMOVE: begin
            slot_present[s] <= 1'b0;
            task_count <= task_count - CNT_W'(1);
            if (task_count == CNT_W'(1)) begin
              ring_head <= '0;
              scan_pointer <= '0;
            end else begin
              if (ring_head == s) ring_head <= nx;
              if (scan_pointer == s) scan_pointer <= nx;
            end
          end
          KIND_TICK: tick_counter <= tick_counter + DATA_W'(1);
          KIND_SCAN: scan_pointer <= ring_next[c];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire
